/* hdl/vpd_pkg.sv */
// Shared constants for the vibration peak detector: register map, field widths.
// No dependencies; used by the top level and its port checker.
package vpd_pkg;

    localparam int ACCEL_W = 16;
    localparam int LEVEL_W = 24;
    localparam int BASE_W  = 32;
    localparam int COEF_W  = 16;
    localparam int APB_AW  = 4;
    localparam int APB_DW  = 32;

    localparam logic [1:0] REG_SENSOR_ENABLED  = 2'd0;
    localparam logic [1:0] REG_BASELINE_WEIGHT = 2'd1;
    localparam logic [1:0] REG_DECAY_FACTOR    = 2'd2;

    localparam logic [COEF_W-1:0] WEIGHT_RESET = 16'd655;
    localparam logic [COEF_W-1:0] DECAY_RESET  = 16'd55706;

    localparam logic [LEVEL_W-1:0] LEVEL_MAX = {LEVEL_W{1'b1}};

endpackage

/* hdl/vibration_peak_detector.sv */
// Vibration peak detector top level: magnitude, baseline tracking, peak hold.
// Uses vpd_pkg for the register map and widths.
//
//  channel   | dir | fields (low bit up)
//  s_axis    | in  | tdata: accel_x[15:0], accel_y[31:16], accel_z[47:32]
//  m_axis    | out | tdata: vibration_level[23:0], magnitude[47:24]
//  apb       | cfg | 0x0 sensor_enabled, 0x4 baseline_weight, 0x8 decay_factor
//
// When enabled, an item passes through the squares, the sum, a restoring square root
// that retires one root bit per cycle, and the baseline and peak updates.
// With the sensor disabled an item goes straight to the output stage and returns zeros.
// The input is not ready while an item is in flight; a held result waits in the
// output register while the next item is accepted and worked on.
// Reset is asynchronous and clears the baseline, seed flag and peak.
module vibration_peak_detector #(
    parameter int SAMPLE_WIDTH = 16,
    parameter int FRAC_BITS    = 8
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    // accel_x [15:0], accel_y [31:16], accel_z [47:32]
    input  logic [3*vpd_pkg::ACCEL_W-1:0] s_axis_tdata,
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // vibration_level [23:0], magnitude [47:24]
    output logic [2*vpd_pkg::LEVEL_W-1:0] m_axis_tdata,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [vpd_pkg::APB_AW-1:0]    paddr,
    input  logic [vpd_pkg::APB_DW-1:0]    pwdata,
    output logic [vpd_pkg::APB_DW-1:0]    prdata,
    output logic                          pready
);

    localparam int RW    = SAMPLE_WIDTH + FRAC_BITS;  // root width
    localparam int SUM_W = 2 * SAMPLE_WIDTH;
    localparam int RAD_W = 2 * RW;
    localparam int REM_W = RW + 2;
    localparam int CNT_W = $clog2(RW + 1);
    localparam int SH    = 16 - FRAC_BITS;
    localparam int MA_W  = vpd_pkg::BASE_W;
    localparam int MB_W  = vpd_pkg::COEF_W;
    localparam int MP_W  = MA_W + MB_W;

    localparam logic [3:0] ST_IDLE = 4'd0;
    localparam logic [3:0] ST_SQX  = 4'd1;
    localparam logic [3:0] ST_SQY  = 4'd2;
    localparam logic [3:0] ST_SQZ  = 4'd3;
    localparam logic [3:0] ST_SUM  = 4'd4;
    localparam logic [3:0] ST_ROOT = 4'd5;
    localparam logic [3:0] ST_DEV  = 4'd6;
    localparam logic [3:0] ST_STEP = 4'd7;
    localparam logic [3:0] ST_OUT  = 4'd8;

    // configuration
    logic                        enabled_reg;
    logic [vpd_pkg::COEF_W-1:0]  weight_reg;
    logic [vpd_pkg::COEF_W-1:0]  decay_reg;
    logic                        cfg_write;
    logic [1:0]                  cfg_index;

    // sequencer and datapath
    logic [3:0]                  state_reg, state_next;
    logic                        run_en_reg;
    logic [SAMPLE_WIDTH-1:0]     abs_x_reg, abs_y_reg, abs_z_reg;
    logic [SUM_W-1:0]            acc_reg;
    logic [RAD_W-1:0]            rad_reg;
    logic [REM_W-1:0]            rem_reg;
    logic [RW-1:0]               root_reg;
    logic [CNT_W-1:0]            cnt_reg;
    logic [vpd_pkg::BASE_W-1:0]  baseline_reg;
    logic                        seeded_reg;
    logic [vpd_pkg::LEVEL_W-1:0] peak_reg;
    logic [vpd_pkg::BASE_W-1:0]  dev_reg;
    logic                        dev_up_reg;
    logic [MP_W-1:0]             prod_reg;

    logic                        out_valid_reg;
    logic [vpd_pkg::LEVEL_W-1:0] out_level_reg, out_mag_reg;

    logic                        in_accept;
    logic                        out_load;
    logic [MA_W-1:0]             mul_a;
    logic [MB_W-1:0]             mul_b;
    logic                        mul_en;

    logic [SAMPLE_WIDTH-1:0]     abs_x, abs_y, abs_z;
    logic [REM_W+1:0]            rem_shift, trial;
    logic                        trial_ok;
    logic [vpd_pkg::BASE_W-1:0]  root32, mag16, base_eff;
    logic [vpd_pkg::BASE_W-1:0]  step;
    logic [vpd_pkg::BASE_W-1:0]  dev_sh;
    logic [vpd_pkg::LEVEL_W-1:0] dev_sat, decayed, peak_new, mag_sat;

    function automatic logic [SAMPLE_WIDTH-1:0] sample_abs(input logic [SAMPLE_WIDTH-1:0] v);
        logic [SAMPLE_WIDTH:0] ext;
        logic [SAMPLE_WIDTH:0] neg;
        ext = {v[SAMPLE_WIDTH-1], v};
        neg = ~ext + 1'b1;
        return ext[SAMPLE_WIDTH] ? neg[SAMPLE_WIDTH-1:0] : ext[SAMPLE_WIDTH-1:0];
    endfunction

    // ---------------------------------------------------------------- APB
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;
    assign cfg_index = paddr[3:2];

    always_comb
    begin
        unique case (cfg_index)
            vpd_pkg::REG_SENSOR_ENABLED:
                prdata = {{(vpd_pkg::APB_DW-1){1'b0}}, enabled_reg};
            vpd_pkg::REG_BASELINE_WEIGHT:
                prdata = {{(vpd_pkg::APB_DW-vpd_pkg::COEF_W){1'b0}}, weight_reg};
            vpd_pkg::REG_DECAY_FACTOR:
                prdata = {{(vpd_pkg::APB_DW-vpd_pkg::COEF_W){1'b0}}, decay_reg};
            default:
                prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enabled_reg <= 1'b1;
            weight_reg  <= vpd_pkg::WEIGHT_RESET;
            decay_reg   <= vpd_pkg::DECAY_RESET;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                vpd_pkg::REG_SENSOR_ENABLED:  enabled_reg <= pwdata[0];
                vpd_pkg::REG_BASELINE_WEIGHT: weight_reg  <= pwdata[vpd_pkg::COEF_W-1:0];
                vpd_pkg::REG_DECAY_FACTOR:    decay_reg   <= pwdata[vpd_pkg::COEF_W-1:0];
                default:                      ;
            endcase
        end
    end

    // ---------------------------------------------------------------- datapath
    assign s_axis_tready = (state_reg == ST_IDLE);
    assign in_accept     = s_axis_tvalid && s_axis_tready;
    assign out_load      = (state_reg == ST_OUT) && (!out_valid_reg || m_axis_tready);

    assign abs_x = sample_abs(s_axis_tdata[SAMPLE_WIDTH-1:0]);
    assign abs_y = sample_abs(s_axis_tdata[vpd_pkg::ACCEL_W +: SAMPLE_WIDTH]);
    assign abs_z = sample_abs(s_axis_tdata[2*vpd_pkg::ACCEL_W +: SAMPLE_WIDTH]);

    // square-root step: bring down two radicand bits, try (root << 2) | 1
    assign rem_shift = {rem_reg, rad_reg[RAD_W-1 -: 2]};
    assign trial     = {2'b00, root_reg, 2'b01};
    assign trial_ok  = rem_shift >= trial;

    assign root32   = MA_W'(root_reg);
    assign mag16    = root32 << SH;
    assign base_eff = seeded_reg ? baseline_reg : mag16;
    assign step     = prod_reg[MP_W-1 -: vpd_pkg::BASE_W];

    assign dev_sh  = dev_reg >> SH;
    assign dev_sat = (dev_sh > MA_W'(vpd_pkg::LEVEL_MAX))
                   ? vpd_pkg::LEVEL_MAX : dev_sh[vpd_pkg::LEVEL_W-1:0];
    assign mag_sat = (root32 > MA_W'(vpd_pkg::LEVEL_MAX))
                   ? vpd_pkg::LEVEL_MAX : root32[vpd_pkg::LEVEL_W-1:0];
    assign decayed = prod_reg[16 +: vpd_pkg::LEVEL_W];
    assign peak_new = (dev_sat > decayed) ? dev_sat : decayed;

    // shared multiplier operand select
    always_comb
    begin
        mul_en = 1'b1;
        mul_a  = '0;
        mul_b  = '0;
        unique case (state_reg)
            ST_SQX:
            begin
                mul_a = MA_W'(abs_x_reg);
                mul_b = MB_W'(abs_x_reg);
            end
            ST_SQY:
            begin
                mul_a = MA_W'(abs_y_reg);
                mul_b = MB_W'(abs_y_reg);
            end
            ST_SQZ:
            begin
                mul_a = MA_W'(abs_z_reg);
                mul_b = MB_W'(abs_z_reg);
            end
            ST_DEV:
            begin
                // deviation against the baseline, weighted for the EMA step
                mul_a = (mag16 >= base_eff) ? mag16 - base_eff : base_eff - mag16;
                mul_b = weight_reg;
            end
            ST_STEP:
            begin
                mul_a = MA_W'(peak_reg);
                mul_b = decay_reg;
            end
            default:
                mul_en = 1'b0;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (mul_en)
            prod_reg <= mul_a * mul_b;
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: if (in_accept) state_next = enabled_reg ? ST_SQX : ST_OUT;
            ST_SQX:  state_next = ST_SQY;
            ST_SQY:  state_next = ST_SQZ;
            ST_SQZ:  state_next = ST_SUM;
            ST_SUM:  state_next = ST_ROOT;
            ST_ROOT: if (cnt_reg == CNT_W'(1)) state_next = ST_DEV;
            ST_DEV:  state_next = ST_STEP;
            ST_STEP: state_next = ST_OUT;
            ST_OUT:  if (out_load) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            run_en_reg    <= 1'b0;
            baseline_reg  <= '0;
            seeded_reg    <= 1'b0;
            peak_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (in_accept)
                run_en_reg <= enabled_reg;
            if (state_reg == ST_DEV)
            begin
                baseline_reg <= base_eff;
                seeded_reg   <= 1'b1;
            end
            if (state_reg == ST_STEP)
                baseline_reg <= dev_up_reg ? baseline_reg + step : baseline_reg - step;
            if (out_load && run_en_reg)
                peak_reg <= peak_new;
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (m_axis_tready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            abs_x_reg <= abs_x;
            abs_y_reg <= abs_y;
            abs_z_reg <= abs_z;
        end
        unique case (state_reg)
            ST_SQY: acc_reg <= prod_reg[SUM_W-1:0];
            ST_SQZ: acc_reg <= acc_reg + prod_reg[SUM_W-1:0];
            ST_SUM:
            begin
                rad_reg  <= {acc_reg + prod_reg[SUM_W-1:0], {(2*FRAC_BITS){1'b0}}};
                rem_reg  <= '0;
                root_reg <= '0;
                cnt_reg  <= CNT_W'(RW);
            end
            ST_ROOT:
            begin
                rad_reg <= rad_reg << 2;
                cnt_reg <= cnt_reg - 1'b1;
                if (trial_ok)
                begin
                    rem_reg  <= REM_W'(rem_shift - trial);
                    root_reg <= {root_reg[RW-2:0], 1'b1};
                end
                else
                begin
                    rem_reg  <= REM_W'(rem_shift);
                    root_reg <= {root_reg[RW-2:0], 1'b0};
                end
            end
            ST_DEV:
            begin
                dev_reg    <= mul_a;
                dev_up_reg <= mag16 >= base_eff;
            end
            default: ;
        endcase
        if (out_load)
        begin
            out_level_reg <= run_en_reg ? peak_new : '0;
            out_mag_reg   <= run_en_reg ? mag_sat : '0;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {out_mag_reg, out_level_reg};

endmodule

/* hdl/vpd_checker.sv */
// Port-level checker for the vibration peak detector, bound to the top level.
// Uses vpd_pkg for port widths.
module vpd_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          s_axis_tvalid,
    input logic                          s_axis_tready,
    input logic                          m_axis_tvalid,
    input logic                          m_axis_tready,
    input logic [2*vpd_pkg::LEVEL_W-1:0] m_axis_tdata,
    input logic                          pready
);

    a_pready_high: assert property (@(posedge clk) pready)
        else $error("pready dropped");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled result changed");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input taken while an item is in flight");

    a_reset_idle: assert property (@(posedge clk) !rst_n |-> !m_axis_tvalid)
        else $error("result shown during reset");

endmodule

bind vibration_peak_detector vpd_checker u_vpd_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .pready        (pready)
);

/* test/vibration_peak_detector_tb.sv */
// Testbench for vibration_peak_detector: streams accelerometer items through the block
// and checks each result against a predictor of the magnitude, baseline and peak hold.
// Depends on vpd_pkg and the vibration_peak_detector RTL only.
`timescale 1ns / 100ps

module vibration_peak_detector_tb;

    localparam logic [1:0] REG_UNUSED = 2'd3;
    localparam int DIRECTED_ROWS = 27;
    localparam int PHASES = 13;
    localparam int PHASE_ITEMS = 145;
    localparam int TAIL_CYCLES = 40;

    typedef struct packed {
        logic [vpd_pkg::LEVEL_W-1:0] level;
        logic [vpd_pkg::LEVEL_W-1:0] mag;
    } reading_t;

    typedef enum logic {ROW_SAMPLE, ROW_WRITE} row_kind_t;

    typedef struct packed {
        row_kind_t                   kind;
        logic [1:0]                  regsel;
        logic [vpd_pkg::COEF_W-1:0]  value;
        logic [vpd_pkg::ACCEL_W-1:0] x;
        logic [vpd_pkg::ACCEL_W-1:0] y;
        logic [vpd_pkg::ACCEL_W-1:0] z;
        logic                        typed;
        logic [vpd_pkg::LEVEL_W-1:0] lvl;
        logic [vpd_pkg::LEVEL_W-1:0] mag;
    } row_t;

    logic                          clk;
    logic                          rst_n;
    logic                          s_axis_tvalid;
    logic                          s_axis_tready;
    logic [3*vpd_pkg::ACCEL_W-1:0] s_axis_tdata;
    logic                          m_axis_tvalid;
    logic                          m_axis_tready;
    logic [2*vpd_pkg::LEVEL_W-1:0] m_axis_tdata;
    logic                          psel;
    logic                          penable;
    logic                          pwrite;
    logic [vpd_pkg::APB_AW-1:0]    paddr;
    logic [vpd_pkg::APB_DW-1:0]    pwdata;
    logic [vpd_pkg::APB_DW-1:0]    prdata;
    logic                          pready;

    // predictor copy of registers and state
    logic                        en_q     = 1'b1;
    logic [vpd_pkg::COEF_W-1:0]  weight_q = vpd_pkg::WEIGHT_RESET;
    logic [vpd_pkg::COEF_W-1:0]  decay_q  = vpd_pkg::DECAY_RESET;
    logic [vpd_pkg::BASE_W-1:0]  base_q   = '0;
    logic                        seeded_q = 1'b0;
    logic [vpd_pkg::LEVEL_W-1:0] peak_q   = '0;

    reading_t readings_due[$];
    row_t     plan [DIRECTED_ROWS];
    int       mismatches = 0;
    int       hold_off = 0;
    bit       no_idle = 1'b0;

    vibration_peak_detector u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    function automatic longint unsigned floor_root(input longint unsigned n);
        longint unsigned acc;
        longint unsigned trial;
        acc = 0;
        for (int b = 25; b >= 0; b--)
        begin
            trial = acc | (64'd1 << b);
            if (trial * trial <= n)
                acc = trial;
        end
        return acc;
    endfunction

    // Advance the predictor by one sample and return the reading it should produce.
    function automatic void track_vibration(input logic [3*vpd_pkg::ACCEL_W-1:0] d,
                                            output reading_t r);
        longint                      ax, ay, az;
        longint unsigned             root;
        logic [vpd_pkg::BASE_W-1:0]  mag16;
        logic [vpd_pkg::BASE_W-1:0]  diff;
        logic [47:0]                 stepv;
        logic [39:0]                 decayed;
        logic [vpd_pkg::LEVEL_W-1:0] dev24;
        if (!en_q)
        begin
            r = '0;
            return;
        end
        ax = longint'($signed(d[15:0]));
        ay = longint'($signed(d[31:16]));
        az = longint'($signed(d[47:32]));
        root = floor_root(longint'(ax * ax + ay * ay + az * az) << 16);
        mag16 = 32'(root << 8);
        // the first enabled sample seeds the baseline
        if (!seeded_q)
        begin
            base_q = mag16;
            seeded_q = 1'b1;
        end
        diff = (mag16 >= base_q) ? mag16 - base_q : base_q - mag16;
        stepv = (48'(diff) * 48'(weight_q)) >> 16;
        if (mag16 >= base_q)
            base_q = base_q + stepv[31:0];
        else
            base_q = base_q - stepv[31:0];
        dev24 = diff[31:8];
        decayed = (40'(peak_q) * 40'(decay_q)) >> 16;
        peak_q = (dev24 > decayed[23:0]) ? dev24 : decayed[23:0];
        r.level = peak_q;
        r.mag = (root > longint'(vpd_pkg::LEVEL_MAX)) ? vpd_pkg::LEVEL_MAX : root[23:0];
    endfunction

    function automatic int draw_gap();
        return no_idle ? 0 : int'($urandom_range(0, 12));
    endfunction

    function automatic row_t row_smp(input int x, input int y, input int z);
        row_t r;
        r = '0;
        r.kind = ROW_SAMPLE;
        r.x = 16'(x);
        r.y = 16'(y);
        r.z = 16'(z);
        return r;
    endfunction

    function automatic row_t row_chk(input int x, input int y, input int z,
                                     input int lvl, input int mag);
        row_t r;
        r = row_smp(x, y, z);
        r.typed = 1'b1;
        r.lvl = 24'(lvl);
        r.mag = 24'(mag);
        return r;
    endfunction

    function automatic row_t row_wr(input logic [1:0] regsel, input int value);
        row_t r;
        r = '0;
        r.kind = ROW_WRITE;
        r.regsel = regsel;
        r.value = 16'(value);
        return r;
    endfunction

    // Mix full-range noise, gravity with small or bursty vibration, and near-zero items.
    function automatic logic [3*vpd_pkg::ACCEL_W-1:0] random_sample();
        logic [63:0] raw;
        int amp;
        int x, y, z;
        raw = {$urandom(), $urandom()};
        case ($urandom_range(0, 3))
            0: return raw[47:0];
            1, 2:
            begin
                amp = ($urandom_range(0, 7) == 0) ? 8000 : 300;
                x = int'($urandom_range(0, 2 * amp)) - amp;
                y = int'($urandom_range(0, 2 * amp)) - amp;
                z = 1000 + int'($urandom_range(0, 2 * amp)) - amp;
            end
            default:
            begin
                x = int'($urandom_range(0, 16)) - 8;
                y = int'($urandom_range(0, 16)) - 8;
                z = int'($urandom_range(0, 16)) - 8;
            end
        endcase
        return {16'(z), 16'(y), 16'(x)};
    endfunction

    task automatic report_mismatch(input string what, input int unsigned got,
                                   input int unsigned want);
        $display("%0t ns: %s: got %0d, expected %0d", $time, what, got, want);
        mismatches++;
    endtask

    // Offer one item after a random gap; hold tvalid high across back-to-back items.
    task automatic send_sample(input logic [3*vpd_pkg::ACCEL_W-1:0] data, input bit typed,
                               input reading_t typed_out);
        int gap;
        reading_t due;
        gap = draw_gap();
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= data;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        track_vibration(data, due);
        readings_due.push_back(typed ? typed_out : due);
        @(negedge clk);
    endtask

    // Drop the input, wait for every pending reading, then let the block settle.
    task automatic settle_block();
        s_axis_tvalid <= 1'b0;
        while (readings_due.size() != 0)
            @(negedge clk);
        repeat (TAIL_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(input logic [1:0] regsel,
                             input logic [vpd_pkg::COEF_W-1:0] value);
        logic [vpd_pkg::APB_DW-1:0] word;
        // garbage in the unused bits must be ignored
        word = $urandom();
        if (regsel == vpd_pkg::REG_SENSOR_ENABLED)
            word[0] = value[0];
        else
            word[15:0] = value;
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {regsel, 2'b00};
        pwdata <= word;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        case (regsel)
            vpd_pkg::REG_SENSOR_ENABLED:  en_q = word[0];
            vpd_pkg::REG_BASELINE_WEIGHT: weight_q = word[15:0];
            vpd_pkg::REG_DECAY_FACTOR:    decay_q = word[15:0];
            default: ;
        endcase
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    always @(posedge clk)
    begin
        reading_t got;
        reading_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got.level = m_axis_tdata[23:0];
            got.mag = m_axis_tdata[47:24];
            if (readings_due.size() == 0)
                report_mismatch("item with nothing pending, level", got.level, 0);
            else
            begin
                want = readings_due.pop_front();
                if (got.level !== want.level)
                    report_mismatch("vibration_level", got.level, want.level);
                if (got.mag !== want.mag)
                    report_mismatch("magnitude", got.mag, want.mag);
            end
        end
    end

    // Receiver: random stalls per item, and a long hold-off when requested.
    initial
    begin
        int w;
        m_axis_tready = 1'b0;
        wait (rst_n === 1'b1);
        @(negedge clk);
        forever
        begin
            if (hold_off > 0)
            begin
                w = hold_off;
                hold_off = 0;
            end
            else
                w = draw_gap();
            if (w > 0)
            begin
                m_axis_tready <= 1'b0;
                repeat (w) @(negedge clk);
            end
            m_axis_tready <= 1'b1;
            @(posedge clk);
            while (!m_axis_tvalid)
                @(posedge clk);
            @(negedge clk);
        end
    end

    initial
    begin
        reading_t                   typed_out;
        logic [vpd_pkg::COEF_W-1:0] weight;
        logic [vpd_pkg::COEF_W-1:0] decay;
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        plan = '{
            row_chk(0, 0, 0, 0, 0),                  // first item seeds the baseline
            row_chk(3000, 4000, 0, 1280000, 1280000),
            row_smp(-32768, -32768, -32768),
            row_smp(32767, 32767, 32767),
            row_smp(32767, -32768, 0),
            row_smp(0, 0, 1000),
            row_smp(1, 0, 0),
            row_smp(-1, -1, -1),
            row_wr(vpd_pkg::REG_SENSOR_ENABLED, 0),
            row_chk(-32768, 32767, -32768, 0, 0),    // disabled: zeros, state held
            row_chk(1234, -5, 77, 0, 0),
            row_wr(vpd_pkg::REG_SENSOR_ENABLED, 1),
            row_wr(vpd_pkg::REG_DECAY_FACTOR, 0),
            row_smp(0, 0, 1000),
            row_smp(0, 500, 1000),
            row_wr(vpd_pkg::REG_DECAY_FACTOR, 65535),
            row_smp(100, 100, 100),
            row_smp(0, 0, 0),
            row_wr(vpd_pkg::REG_BASELINE_WEIGHT, 0),
            row_smp(0, 0, 2000),
            row_smp(0, 0, 1000),
            row_wr(vpd_pkg::REG_BASELINE_WEIGHT, 65535),
            row_smp(0, 0, 5000),
            row_smp(0, 0, 1000),
            row_wr(REG_UNUSED, 0),                   // no such register: ignored
            row_wr(vpd_pkg::REG_BASELINE_WEIGHT, 655),
            row_wr(vpd_pkg::REG_DECAY_FACTOR, 55706)
        };
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (plan[i])
        begin
            if (plan[i].kind == ROW_WRITE)
            begin
                settle_block();
                write_reg(plan[i].regsel, plan[i].value);
            end
            else
            begin
                typed_out.level = plan[i].lvl;
                typed_out.mag = plan[i].mag;
                send_sample({plan[i].z, plan[i].y, plan[i].x}, plan[i].typed, typed_out);
            end
        end

        for (int phase = 0; phase < PHASES; phase++)
        begin
            settle_block();
            case (phase % 5)
                0: weight = vpd_pkg::WEIGHT_RESET;
                1: weight = '0;
                2: weight = '1;
                3: weight = 16'($urandom_range(1, 8000));
                default: weight = 16'($urandom());
            endcase
            case (phase % 4)
                0: decay = vpd_pkg::DECAY_RESET;
                1: decay = '1;
                2: decay = '0;
                default: decay = 16'($urandom());
            endcase
            write_reg(vpd_pkg::REG_SENSOR_ENABLED, (phase == 6) ? 16'd0 : 16'd1);
            write_reg(vpd_pkg::REG_BASELINE_WEIGHT, weight);
            write_reg(vpd_pkg::REG_DECAY_FACTOR, decay);
            no_idle = (phase % 4 == 3);
            // stall the output long enough to back up the input
            if (phase == 2)
                hold_off = 400;
            for (int n = 0; n < PHASE_ITEMS; n++)
                send_sample(random_sample(), 1'b0, '0);
        end

        settle_block();
        if (mismatches == 0)
            $display("vibration_peak_detector test passed");
        else
            $display("vibration_peak_detector test failed");
        $finish;
    end

    initial
    begin
        #20000000;
        $display("vibration_peak_detector test failed");
        $finish;
    end

endmodule

/* filelist.f */
hdl/vpd_pkg.sv
hdl/vibration_peak_detector.sv
hdl/vpd_checker.sv
test/vibration_peak_detector_tb.sv
